// ===== src/bwsr_pkg.sv =====
// Shared types, constants and helpers for the device tree blob word search and replace block.
package bwsr_pkg;

  localparam int WINDOW_BYTES = 8;
  localparam int FILL_W       = $clog2(WINDOW_BYTES + 1);
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [31:0] FDT_MAGIC    = 32'hD00D_FEED;
  localparam logic [31:0] MIN_TOTAL    = 32'd32;
  localparam logic [31:0] HEADER_BYTES = 32'd8;

  typedef enum logic [1:0] {
    V_PENDING,
    V_OK,
    V_MAGIC,
    V_RANGE
  } verdict_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_BAD_MAGIC,
    STAT_RANGE,
    STAT_NOT_FOUND
  } status_t;

  typedef enum logic [2:0] {
    REG_PAIR_MODE,
    REG_MATCH_WORD_A,
    REG_MATCH_WORD_B,
    REG_REPLACE_WORD_A,
    REG_REPLACE_WORD_B,
    REG_BLOB_CAPACITY
  } cfg_index_t;

  typedef enum logic {
    FS_RUN,
    FS_FLUSH
  } front_state_t;

  typedef struct packed {
    logic        pair_mode;
    logic [31:0] match_word_a;
    logic [31:0] match_word_b;
    logic [31:0] replace_word_a;
    logic [31:0] replace_word_b;
    logic [31:0] blob_capacity;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_status;
    logic [1:0] status_code;
    logic       run_end;
  } result_t;

  function automatic logic [7:0] word_byte(input logic [31:0] first,
                                           input logic [31:0] second,
                                           input logic [2:0]  j);
    logic [31:0] w;
    logic [7:0]  b;
    w = j[2] ? second : first;
    case (j[1:0])
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

endpackage

// ===== src/bwsr_front.sv =====
// Front part: byte window, header check, first-match replacement and flush sequencing.
module bwsr_front
  import bwsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] blob_byte,
  input  logic       final_byte,
  input  logic       q_full,
  output logic       q_push,
  output result_t    q_data
);

  logic [7:0]        win [WINDOW_BYTES];
  logic [FILL_W-1:0] fill;
  logic [31:0]       offset;
  logic [31:0]       total;
  verdict_t          verdict;
  logic              match_done;
  front_state_t      state;

  logic [7:0]        w  [WINDOW_BYTES];
  logic [7:0]        sh [WINDOW_BYTES];
  logic [FILL_W-1:0] n;
  logic [FILL_W-1:0] len;
  logic [31:0]       hdr_magic;
  logic [31:0]       hdr_total;
  verdict_t          calc;
  verdict_t          verdict_eff;
  logic [31:0]       total_eff;
  logic              accept;
  logic              emit;
  logic              status_emit;
  logic              decide;
  logic              range_ok;
  logic              pat_ok;
  logic [WINDOW_BYTES-1:0] eqv;
  logic              hit;
  logic [7:0]        emit_byte;
  status_t           code;

  always_comb begin
    in_stall    = !(state == FS_RUN && !q_full);
    accept      = in_valid && !in_stall;
    n           = (state == FS_RUN) ? fill + 1'b1 : fill;
    len         = cfg.pair_mode ? FILL_W'(8) : FILL_W'(4);
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      w[i] = (state == FS_RUN && fill == FILL_W'(i)) ? blob_byte : win[i];
    end

    hdr_magic = {w[0], w[1], w[2], w[3]};
    hdr_total = {w[4], w[5], w[6], w[7]};
    if (cfg.blob_capacity < HEADER_BYTES || n < FILL_W'(4)) begin
      calc = V_RANGE;
    end else if (hdr_magic != FDT_MAGIC) begin
      calc = V_MAGIC;
    end else if (n < FILL_W'(HEADER_BYTES)) begin
      calc = V_RANGE;
    end else if (hdr_total < MIN_TOTAL || hdr_total > cfg.blob_capacity) begin
      calc = V_RANGE;
    end else begin
      calc = V_OK;
    end
    verdict_eff = (verdict == V_PENDING) ? calc : verdict;
    total_eff   = (verdict == V_PENDING) ? hdr_total : total;

    emit        = (accept && (final_byte || n == FILL_W'(WINDOW_BYTES))) ||
                  (state == FS_FLUSH && !q_full && fill != '0);
    status_emit = state == FS_FLUSH && !q_full && fill == '0;
    decide      = accept && verdict == V_PENDING &&
                  (final_byte || n == FILL_W'(WINDOW_BYTES));

    range_ok = ({1'b0, offset} + 33'(len)) <= {1'b0, total_eff};
    for (int j = 0; j < WINDOW_BYTES; j++) begin
      eqv[j] = w[j] == word_byte(cfg.match_word_a, cfg.match_word_b, 3'(j));
    end
    pat_ok = cfg.pair_mode ? &eqv : &eqv[3:0];
    hit    = verdict_eff == V_OK && !match_done && n >= len && range_ok && pat_ok;

    emit_byte = hit ? word_byte(cfg.replace_word_a, cfg.replace_word_b, 3'd0) : w[0];
    for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
      sh[i] = (hit && FILL_W'(i + 1) < len) ?
              word_byte(cfg.replace_word_a, cfg.replace_word_b, 3'(i + 1)) : w[i + 1];
    end
    sh[WINDOW_BYTES-1] = '0;

    if (verdict == V_OK) begin
      code = match_done ? STAT_OK : STAT_NOT_FOUND;
    end else if (verdict == V_MAGIC) begin
      code = STAT_BAD_MAGIC;
    end else begin
      code = STAT_RANGE;
    end

    q_push = emit || status_emit;
    if (status_emit) begin
      q_data = '{out_byte: 8'd0, is_status: 1'b1, status_code: code, run_end: 1'b1};
    end else begin
      q_data = '{out_byte: emit_byte, is_status: 1'b0, status_code: STAT_OK,
                 run_end: (state == FS_RUN) && !final_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      win <= sh;
    end else if (accept) begin
      win <= w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FS_RUN;
      fill       <= '0;
      offset     <= '0;
      total      <= '0;
      verdict    <= V_PENDING;
      match_done <= 1'b0;
    end else if (status_emit) begin
      state      <= FS_RUN;
      fill       <= '0;
      offset     <= '0;
      total      <= '0;
      verdict    <= V_PENDING;
      match_done <= 1'b0;
    end else begin
      if (decide) begin
        verdict <= calc;
        if (calc == V_OK) begin
          total <= hdr_total;
        end
      end
      if (emit) begin
        fill <= n - 1'b1;
        if (offset != '1) begin
          offset <= offset + 32'd1;
        end
        if (hit) begin
          match_done <= 1'b1;
        end
      end else if (accept) begin
        fill <= n;
      end
      if (accept && final_byte) begin
        state <= FS_FLUSH;
      end
    end
  end

endmodule

// ===== src/bwsr_queue.sv =====
// Result queue between the front part and the output channel.
module bwsr_queue
  import bwsr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t       mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  assign full      = count == CW'(DEPTH);
  assign out_valid = count != '0;
  assign pop       = out_valid && !out_stall;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/blob_word_search_replace_top.sv =====
// Top level of the device tree blob word search and replace block.
// Takes one blob byte per cycle when not stalled and returns the bytes in order through an
// eight-byte window, with the first in-range occurrence of the configured word (or word pair)
// replaced once the header has checked out. In steady flow a byte is taken every clock; once
// eight bytes are held, the oldest leaves on the clock that a byte is taken and is written into
// the result queue and offered once it reaches the head. After the final byte, the front part
// flushes the held bytes into the queue, one result per cycle while it is not full, then the
// status; no new byte is taken meanwhile, and the input also stalls while the queue is full.
// Write the configuration registers only while the block is idle.
module blob_word_search_replace_top
  import bwsr_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  blob_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        is_status,
  output logic [1:0]  status_code,
  output logic        run_end
);

  cfg_t    cfg;
  logic    q_full;
  logic    q_push;
  result_t q_data;
  result_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PAIR_MODE:      cfg.pair_mode      <= cfg_data[0];
        REG_MATCH_WORD_A:   cfg.match_word_a   <= cfg_data;
        REG_MATCH_WORD_B:   cfg.match_word_b   <= cfg_data;
        REG_REPLACE_WORD_A: cfg.replace_word_a <= cfg_data;
        REG_REPLACE_WORD_B: cfg.replace_word_b <= cfg_data;
        REG_BLOB_CAPACITY:  cfg.blob_capacity  <= cfg_data;
        default: ;
      endcase
    end
  end

  bwsr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .blob_byte  (blob_byte),
    .final_byte (final_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_data)
  );

  bwsr_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_byte    = head.out_byte;
  assign is_status   = head.is_status;
  assign status_code = head.status_code;
  assign run_end     = head.run_end;

endmodule
